/* rtl/core/ptw_pkg.sv */
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared widths, codes, microcode word layout and control ROM for the
// four-level page-table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

  // Default store size in table pages
  localparam int TABLE_PAGES_DEF = 8;
  localparam int WORDS_PER_PAGE  = 512;

  // Field widths
  localparam int IDX_W     = 12;
  localparam int DATA_W    = 64;
  localparam int VA_W      = 64;
  localparam int PA_W      = 52;
  localparam int FRAME_W   = 40;
  localparam int SLOT_W    = 10;
  localparam int ENT_IDX_W = 9;
  localparam int CFG_IDX_W = 1;

  // Input word kinds
  localparam logic KIND_WRITE     = 1'b0;
  localparam logic KIND_TRANSLATE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_TABLE      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECT_MAP_BASE = 1'd1;

  localparam logic [VA_W-1:0] DIRECT_MAP_RESET = 64'hFFFF_8000_0000_0000;

  // Entry flag bit positions
  localparam int BIT_PRESENT = 0;
  localparam int BIT_USER    = 2;
  localparam int BIT_LARGE   = 7;

  // Walk levels
  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  // Datapath micro-operations
  typedef enum logic [2:0] {
    OP_ACCEPT = 3'd0,
    OP_CHECK  = 3'd1,
    OP_ISSUE  = 3'd2,
    OP_EVAL   = 3'd3,
    OP_EMIT   = 3'd4
  } uop_t;

  // Branch conditions
  typedef enum logic [1:0] {
    C_WALK     = 2'd0,
    C_END      = 2'd1,
    C_SLOT     = 2'd2,
    C_OUT_FREE = 2'd3
  } cond_t;

  typedef logic [2:0] step_t;

  localparam step_t S_IDLE  = 3'd0;
  localparam step_t S_CHECK = 3'd1;
  localparam step_t S_ISSUE = 3'd2;
  localparam step_t S_EVAL  = 3'd3;
  localparam step_t S_EMIT  = 3'd4;

  typedef struct packed {
    logic  in_ready;
    uop_t  op;
    cond_t cond;
    step_t on_true;
    step_t on_false;
  } uword_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic walk;
    logic end_now;
    logic slot_ok;
    logic out_free;
  } ptw_stat_t;

  // Control program: one word per step
  function automatic uword_t ucode_rom(step_t s);
    uword_t w;
    case (s)
      S_IDLE:  w = '{1'b1, OP_ACCEPT, C_WALK,     S_CHECK, S_IDLE};
      S_CHECK: w = '{1'b0, OP_CHECK,  C_END,      S_EMIT,  S_ISSUE};
      S_ISSUE: w = '{1'b0, OP_ISSUE,  C_SLOT,     S_EVAL,  S_ISSUE};
      S_EVAL:  w = '{1'b0, OP_EVAL,   C_END,      S_EMIT,  S_ISSUE};
      S_EMIT:  w = '{1'b0, OP_EMIT,   C_OUT_FREE, S_IDLE,  S_EMIT};
      default: w = '{1'b0, OP_ACCEPT, C_WALK,     S_IDLE,  S_IDLE};
    endcase
    return w;
  endfunction

  // Nine index bits of the virtual address for a level
  function automatic logic [ENT_IDX_W-1:0] level_index(logic [VA_W-1:0] va,
                                                       logic [1:0] lvl);
    logic [ENT_IDX_W-1:0] idx;
    case (lvl)
      LVL_PML4: idx = va[47:39];
      LVL_PDPT: idx = va[38:30];
      LVL_PD:   idx = va[29:21];
      LVL_PT:   idx = va[20:12];
      default:  idx = va[47:39];
    endcase
    return idx;
  endfunction

endpackage

/* rtl/core/ptw_in_if.sv */
// ----------------------------------------------------------------------------
// ptw_in_if
// Input channel: table word writes and translate requests.
// ----------------------------------------------------------------------------
interface ptw_in_if import ptw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [IDX_W-1:0]     word_index;
  logic [DATA_W-1:0]    word_data;
  logic [VA_W-1:0]      virtual_address;
  logic                 user_only;

  modport source (
    output valid, kind, word_index, word_data, virtual_address, user_only,
    input  ready
  );
  modport sink (
    input  valid, kind, word_index, word_data, virtual_address, user_only,
    output ready
  );
endinterface

/* rtl/core/ptw_out_if.sv */
// ----------------------------------------------------------------------------
// ptw_out_if
// Result channel: translated physical address and fault flag.
// ----------------------------------------------------------------------------
interface ptw_out_if import ptw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PA_W-1:0]  physical_address;
  logic             fault;

  modport source (output valid, physical_address, fault, input ready);
  modport sink   (input valid, physical_address, fault, output ready);
endinterface

/* rtl/core/ptw_cfg_if.sv */
// ----------------------------------------------------------------------------
// ptw_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ptw_cfg_if import ptw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/page_table_walk_translate.sv */
// ----------------------------------------------------------------------------
// page_table_walk_translate
// Four-level page-table walker over a local store of table words.
// ----------------------------------------------------------------------------
// A write word loads one 64-bit table word; it returns nothing. A translate
// word returns one result. It resolves without a walk after the check step
// (root zero, user range fault, direct-map hit); otherwise it reads up to
// four levels. Each level costs an issue step and an evaluate step of the
// microprogram around the single registered read port of the table store.
// When TABLE_PAGES is not a power of two the slot mapping first loads the
// frame and then reduces it eight bits at a time for each level. The emit
// step waits until the output register is free. One walk is in flight at a
// time; the next word is taken once the result is in the output register.
// ----------------------------------------------------------------------------
module page_table_walk_translate import ptw_pkg::*; #(
  parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ptw_in_if.sink     in_ch,
  ptw_out_if.source  out_ch,
  ptw_cfg_if.sink    cfg_ch
);

  logic [PA_W-1:0] root_table_r;
  logic [VA_W-1:0] direct_map_base_r;
  uword_t          uw;
  ptw_stat_t       stat;

  // Configuration registers, always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_table_r      <= '0;
      direct_map_base_r <= DIRECT_MAP_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ROOT_TABLE:      root_table_r      <= cfg_ch.data[PA_W-1:0];
        REG_DIRECT_MAP_BASE: direct_map_base_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  ptw_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .uw    (uw)
  );

  ptw_dp #(.TABLE_PAGES(TABLE_PAGES)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .uw              (uw),
    .root_table      (root_table_r),
    .direct_map_base (direct_map_base_r),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .stat            (stat)
  );

endmodule

/* rtl/core/ptw_ram.sv */
// ----------------------------------------------------------------------------
// ptw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/ptw_slot.sv */
// ----------------------------------------------------------------------------
// ptw_slot
// Maps a table frame number to its page slot (frame modulo page count).
// Power-of-two page counts take the low bits at once; other counts reduce
// the frame eight bits per cycle.
// ----------------------------------------------------------------------------
module ptw_slot import ptw_pkg::*; #(
  parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req,
  input  logic [FRAME_W-1:0] frame,
  output logic [SLOT_W-1:0]  slot,
  output logic               done
);

  localparam bit POW2 = ((TABLE_PAGES & (TABLE_PAGES - 1)) == 0);

  if (POW2) begin : g_mask
    // Slot is the low frame bits
    assign slot = SLOT_W'(frame & FRAME_W'(TABLE_PAGES - 1));
    assign done = req;
  end else begin : g_reduce
    localparam logic [SLOT_W:0] MODULUS = (SLOT_W + 1)'(TABLE_PAGES);
    localparam int              CHUNKS  = FRAME_W / 8;

    logic [FRAME_W-1:0] sh_r;
    logic [SLOT_W-1:0]  rem_r;
    logic [2:0]         cnt_r;
    logic               busy_r;
    logic               done_r;
    logic [SLOT_W:0]    rem_nxt;

    // Fold the next eight frame bits into the remainder
    always_comb begin
      rem_nxt = {1'b0, rem_r};
      for (int i = 0; i < 8; i++) begin
        rem_nxt = {rem_nxt[SLOT_W-1:0], sh_r[FRAME_W-1-i]};
        if (rem_nxt >= MODULUS) begin
          rem_nxt = rem_nxt - MODULUS;
        end
      end
    end

    // Control: start on request, finish after all chunks
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        busy_r <= 1'b0;
        done_r <= 1'b0;
        cnt_r  <= '0;
      end else if (!req) begin
        busy_r <= 1'b0;
        done_r <= 1'b0;
      end else if (!busy_r && !done_r) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'(CHUNKS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 3'd1;
        if (cnt_r == 3'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end

    // Datapath: load frame, shift a byte per cycle
    always_ff @(posedge clk) begin
      if (req && !busy_r && !done_r) begin
        sh_r  <= frame;
        rem_r <= '0;
      end else if (busy_r) begin
        sh_r  <= {sh_r[FRAME_W-9:0], 8'd0};
        rem_r <= rem_nxt[SLOT_W-1:0];
      end
    end

    assign slot = rem_r;
    assign done = done_r;
  end

endmodule

/* rtl/core/ptw_seq.sv */
// ----------------------------------------------------------------------------
// ptw_seq
// Microcode sequencer: step counter, control ROM and two-way branch.
// ----------------------------------------------------------------------------
module ptw_seq import ptw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ptw_stat_t stat,
  output uword_t    uw
);

  step_t step_r;
  step_t step_nxt;
  logic  taken;

  assign uw = ucode_rom(step_r);

  // Evaluate the branch condition of the current word
  always_comb begin
    case (uw.cond)
      C_WALK:     taken = stat.walk;
      C_END:      taken = stat.end_now;
      C_SLOT:     taken = stat.slot_ok;
      C_OUT_FREE: taken = stat.out_free;
      default:    taken = 1'b0;
    endcase
    step_nxt = taken ? uw.on_true : uw.on_false;
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

/* rtl/core/ptw_dp.sv */
// ----------------------------------------------------------------------------
// ptw_dp
// Walk datapath: table store, slot mapping, range and window checks, entry
// evaluation and the result register.
// ----------------------------------------------------------------------------
module ptw_dp import ptw_pkg::*; #(
  parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  uword_t            uw,
  input  logic [PA_W-1:0]   root_table,
  input  logic [VA_W-1:0]   direct_map_base,
  ptw_in_if.sink            in_ch,
  ptw_out_if.source         out_ch,
  output ptw_stat_t         stat
);

  localparam int STORE_WORDS = TABLE_PAGES * WORDS_PER_PAGE;
  localparam int ADDR_W      = $clog2(STORE_WORDS);

  logic               in_acc;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [DATA_W-1:0]  rd_data;

  logic [VA_W-1:0]    va_r;
  logic               user_r;
  logic [DATA_W-1:0]  ent_r;
  logic [1:0]         lvl_r;
  logic [PA_W-1:0]    pa_r;
  logic               fault_r;

  logic               out_valid_r;
  logic [PA_W-1:0]    out_pa_r;
  logic               out_fault_r;

  logic [SLOT_W-1:0]  slot;
  logic               slot_done;

  logic [VA_W:0]      diff;
  logic               in_window;
  logic               user_bad;
  logic               chk_end;
  logic               chk_fault;
  logic [PA_W-1:0]    chk_pa;

  logic               ent_ok;
  logic               ev_end;
  logic               ev_fault;
  logic [PA_W-1:0]    ev_pa;
  logic               out_free;

  // Input handshake
  assign in_ch.ready = uw.in_ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Store writes, out-of-range indexes dropped
  assign wr_en   = in_acc && (in_ch.kind == KIND_WRITE)
                   && (32'(in_ch.word_index) < 32'(STORE_WORDS));
  assign wr_addr = ADDR_W'(in_ch.word_index);

  // Slot of the current table
  ptw_slot #(.TABLE_PAGES(TABLE_PAGES)) u_slot (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (uw.op == OP_ISSUE),
    .frame (ent_r[51:12]),
    .slot  (slot),
    .done  (slot_done)
  );

  // Entry read for the current level
  assign rd_en   = (uw.op == OP_ISSUE) && slot_done;
  assign rd_addr = ADDR_W'({slot, level_index(va_r, lvl_r)});

  ptw_ram #(.WIDTH(DATA_W), .DEPTH(STORE_WORDS)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_ch.word_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Root, user range and direct-map window checks
  always_comb begin
    diff      = {1'b0, va_r} - {1'b0, direct_map_base};
    in_window = !diff[VA_W] && (diff[63:46] == '0);
    user_bad  = (va_r[63:47] != '0) || (va_r[46:12] == '0);
    chk_end   = 1'b0;
    chk_fault = 1'b0;
    chk_pa    = '0;
    if (root_table == '0) begin
      chk_end   = 1'b1;
      chk_fault = 1'b1;
    end else if (user_r) begin
      if (user_bad) begin
        chk_end   = 1'b1;
        chk_fault = 1'b1;
      end
    end else if (in_window) begin
      chk_end = 1'b1;
      chk_pa  = diff[PA_W-1:0];
    end
  end

  // Evaluate the entry just read
  always_comb begin
    ent_ok   = rd_data[BIT_PRESENT] && (!user_r || rd_data[BIT_USER]);
    ev_end   = 1'b0;
    ev_fault = 1'b0;
    ev_pa    = '0;
    if (!ent_ok) begin
      ev_end   = 1'b1;
      ev_fault = 1'b1;
    end else if (lvl_r == LVL_PDPT && rd_data[BIT_LARGE]) begin
      ev_end = 1'b1;
      ev_pa  = {rd_data[51:30], va_r[29:0]};
    end else if (lvl_r == LVL_PD && rd_data[BIT_LARGE]) begin
      ev_end = 1'b1;
      ev_pa  = {rd_data[51:21], va_r[20:0]};
    end else if (lvl_r == LVL_PT) begin
      ev_end = 1'b1;
      ev_pa  = {rd_data[51:12], va_r[11:0]};
    end
  end

  // Status back to the sequencer
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    stat.walk     = in_acc && (in_ch.kind == KIND_TRANSLATE);
    stat.slot_ok  = slot_done;
    stat.out_free = out_free;
    case (uw.op)
      OP_CHECK: stat.end_now = chk_end;
      OP_EVAL:  stat.end_now = ev_end;
      default:  stat.end_now = 1'b0;
    endcase
  end

  // Walk registers
  always_ff @(posedge clk) begin
    case (uw.op)
      OP_ACCEPT: begin
        if (stat.walk) begin
          va_r   <= in_ch.virtual_address;
          user_r <= in_ch.user_only;
        end
      end
      OP_CHECK: begin
        ent_r   <= {{(DATA_W - PA_W){1'b0}}, root_table};
        lvl_r   <= LVL_PML4;
        pa_r    <= chk_pa;
        fault_r <= chk_fault;
      end
      OP_EVAL: begin
        pa_r    <= ev_pa;
        fault_r <= ev_fault;
        if (!ev_end) begin
          ent_r <= rd_data;
          lvl_r <= lvl_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (uw.op == OP_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.op == OP_EMIT && out_free) begin
      out_pa_r    <= fault_r ? '0 : pa_r;
      out_fault_r <= fault_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.physical_address = out_pa_r;
  assign out_ch.fault            = out_fault_r;

endmodule
